[rtl/rgbcrop_pkg.sv]
// Shared constants, types and helpers for the RGB565 crop and red emphasis block.
`default_nettype none
package rgbcrop_pkg;

    localparam int unsigned FRAME_WIDTH  = 160;
    localparam int unsigned FRAME_HEIGHT = 120;
    localparam int unsigned CROP_WIDTH   = 96;
    localparam int unsigned CROP_HEIGHT  = 96;

    localparam int unsigned COL_W  = (FRAME_WIDTH  > 2) ? $clog2(FRAME_WIDTH)  : 1;
    localparam int unsigned ROW_W  = (FRAME_HEIGHT > 2) ? $clog2(FRAME_HEIGHT) : 1;
    localparam int unsigned XS_W   = 7;
    localparam int unsigned YS_W   = 5;
    localparam int unsigned XC_W   = (COL_W > XS_W) ? COL_W : XS_W;
    localparam int unsigned YC_W   = (ROW_W > YS_W) ? ROW_W : YS_W;
    localparam int unsigned IDX_W  = 14;
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    localparam logic [15:0] PURE_RED_565 = 16'hF800;
    localparam logic [23:0] PURE_RED_888 = 24'hFF0000;

    typedef enum logic [2:0] {
        REG_ENABLE = 3'd0,
        REG_FLOOR  = 3'd1,
        REG_MARGIN = 3'd2,
        REG_XSTART = 3'd3,
        REG_YSTART = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic            enable_red_emphasis;
        logic [7:0]      red_floor;
        logic [7:0]      red_margin;
        logic [XS_W-1:0] crop_x_start;
        logic [YS_W-1:0] crop_y_start;
    } cfg_t;

    typedef struct packed {
        logic [15:0]      pixel;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } pos_pixel_t;

    function automatic logic [7:0] expand5(input logic [4:0] v);
        expand5 = {v, v[4:2]};
    endfunction

    function automatic logic [7:0] expand6(input logic [5:0] v);
        expand6 = {v, v[5:4]};
    endfunction

endpackage
`default_nettype wire

[rtl/rgb565_crop_red_emphasis_top.sv]
// Top level of the RGB565 center crop with red emphasis.
// A pixel inside the window passes through the input register and then the result register before it is offered.
// Throughput: 1 pixel per cycle while the result port is not stalled, set by the input and result registers.
// Pixels outside the window are dropped from the input register in the cycle after their transfer.
// Reset clears the column and row counters and both valid flags,
// and loads the register defaults (emphasis on, floor 150, margin 60, start 32/12).
`default_nettype none
module rgb565_crop_red_emphasis_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [rgbcrop_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [rgbcrop_pkg::DATA_W-1:0]  pwdata,
    output logic      [rgbcrop_pkg::DATA_W-1:0]  prdata,
    output logic                                 pready,
    input  wire logic                            pixel_valid,
    output logic                                 pixel_ready,
    input  wire logic [15:0]                     pixel_in,
    input  wire logic                            frame_start,
    output logic                                 result_valid,
    input  wire logic                            result_ready,
    output logic      [15:0]                     display_pixel,
    output logic      [23:0]                     feature_rgb,
    output logic      [rgbcrop_pkg::IDX_W-1:0]   crop_index,
    output logic                                 emphasized,
    output logic                                 last_of_crop
);
    import rgbcrop_pkg::*;

    cfg_t       cfg;
    pos_pixel_t s1_data;
    logic       s1_valid;
    logic       take;

    rgbcrop_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rgbcrop_pos u_pos (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel_in    (pixel_in),
        .frame_start (frame_start),
        .take        (take),
        .s1_valid    (s1_valid),
        .s1_data     (s1_data)
    );

    rgbcrop_proc u_proc (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .s1_valid      (s1_valid),
        .s1_data       (s1_data),
        .take          (take),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .display_pixel (display_pixel),
        .feature_rgb   (feature_rgb),
        .crop_index    (crop_index),
        .emphasized    (emphasized),
        .last_of_crop  (last_of_crop)
    );

endmodule
`default_nettype wire

[rtl/rgbcrop_cfg.sv]
// APB register file for emphasis and crop window settings.
`default_nettype none
module rgbcrop_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [rgbcrop_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [rgbcrop_pkg::DATA_W-1:0]  pwdata,
    output logic      [rgbcrop_pkg::DATA_W-1:0]  prdata,
    output logic                                 pready,
    output rgbcrop_pkg::cfg_t                    cfg
);
    import rgbcrop_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_ENABLE: cfg_next.enable_red_emphasis = pwdata[0];
                REG_FLOOR:  cfg_next.red_floor           = pwdata[7:0];
                REG_MARGIN: cfg_next.red_margin          = pwdata[7:0];
                REG_XSTART: cfg_next.crop_x_start        = pwdata[XS_W-1:0];
                REG_YSTART: cfg_next.crop_y_start        = pwdata[YS_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ENABLE: prdata = DATA_W'(cfg_reg.enable_red_emphasis);
            REG_FLOOR:  prdata = DATA_W'(cfg_reg.red_floor);
            REG_MARGIN: prdata = DATA_W'(cfg_reg.red_margin);
            REG_XSTART: prdata = DATA_W'(cfg_reg.crop_x_start);
            REG_YSTART: prdata = DATA_W'(cfg_reg.crop_y_start);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable_red_emphasis <= 1'b1;
            cfg_reg.red_floor           <= 8'd150;
            cfg_reg.red_margin          <= 8'd60;
            cfg_reg.crop_x_start        <= XS_W'(32);
            cfg_reg.crop_y_start        <= YS_W'(12);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

[rtl/rgbcrop_pos.sv]
// Input register with frame column and row tracking.
`default_nettype none
module rgbcrop_pos (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     pixel_valid,
    output logic                          pixel_ready,
    input  wire logic [15:0]              pixel_in,
    input  wire logic                     frame_start,
    input  wire logic                     take,
    output logic                          s1_valid,
    output rgbcrop_pkg::pos_pixel_t       s1_data
);
    import rgbcrop_pkg::*;

    localparam logic [COL_W:0] COL_END = (COL_W+1)'(FRAME_WIDTH);
    localparam logic [ROW_W:0] ROW_END = (ROW_W+1)'(FRAME_HEIGHT);

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic             valid_reg;
    logic             valid_next;
    pos_pixel_t       data_reg;
    logic [COL_W-1:0] placed_col;
    logic [ROW_W-1:0] placed_row;
    logic [COL_W:0]   col_inc;
    logic [ROW_W:0]   row_inc;
    logic             accept;

    assign pixel_ready = !valid_reg || take;
    assign accept      = pixel_valid && pixel_ready;
    assign placed_col  = frame_start ? '0 : col_reg;
    assign placed_row  = frame_start ? '0 : row_reg;
    assign col_inc     = {1'b0, placed_col} + (COL_W+1)'(1);
    assign row_inc     = {1'b0, placed_row} + (ROW_W+1)'(1);

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next = 1'b1;
            if (col_inc == COL_END)
            begin
                col_next = '0;
                row_next = (row_inc == ROW_END) ? '0 : row_inc[ROW_W-1:0];
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
                row_next = placed_row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg.pixel <= pixel_in;
            data_reg.col   <= placed_col;
            data_reg.row   <= placed_row;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_data  = data_reg;

endmodule
`default_nettype wire

[rtl/rgbcrop_proc.sv]
// Window test, color expansion, red emphasis and result register.
`default_nettype none
module rgbcrop_proc (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  rgbcrop_pkg::cfg_t             cfg,
    input  wire logic                     s1_valid,
    input  rgbcrop_pkg::pos_pixel_t       s1_data,
    output logic                          take,
    output logic                          result_valid,
    input  wire logic                     result_ready,
    output logic [15:0]                   display_pixel,
    output logic [23:0]                   feature_rgb,
    output logic [rgbcrop_pkg::IDX_W-1:0] crop_index,
    output logic                          emphasized,
    output logic                          last_of_crop
);
    import rgbcrop_pkg::*;

    localparam logic [IDX_W-1:0] IDX_CW = IDX_W'(CROP_WIDTH);

    logic [XC_W-1:0]  col_x;
    logic [XC_W-1:0]  xs_x;
    logic [YC_W-1:0]  row_x;
    logic [YC_W-1:0]  ys_x;
    logic [XC_W-1:0]  dx;
    logic [YC_W-1:0]  dy;
    logic             in_win;
    logic [7:0]       r8;
    logic [7:0]       g8;
    logic [7:0]       b8;
    logic             hit;
    logic             out_free;
    logic             load;
    logic             valid_reg;
    logic             valid_next;
    logic [15:0]      pix_reg;
    logic [23:0]      rgb_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             hit_reg;
    logic             last_reg;

    assign col_x = XC_W'(s1_data.col);
    assign xs_x  = XC_W'(cfg.crop_x_start);
    assign row_x = YC_W'(s1_data.row);
    assign ys_x  = YC_W'(cfg.crop_y_start);
    assign dx    = col_x - xs_x;
    assign dy    = row_x - ys_x;

    assign in_win = (col_x >= xs_x) && (row_x >= ys_x)
                 && (32'(dx) < CROP_WIDTH) && (32'(dy) < CROP_HEIGHT);

    assign r8 = expand5(s1_data.pixel[15:11]);
    assign g8 = expand6(s1_data.pixel[10:5]);
    assign b8 = expand5(s1_data.pixel[4:0]);

    assign hit = cfg.enable_red_emphasis && (r8 > cfg.red_floor)
              && ({1'b0, r8} > ({1'b0, g8} + {1'b0, cfg.red_margin}))
              && ({1'b0, r8} > ({1'b0, b8} + {1'b0, cfg.red_margin}));

    assign out_free = !valid_reg || result_ready;
    assign take     = s1_valid && (!in_win || out_free);
    assign load     = s1_valid && in_win && out_free;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_free)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pix_reg  <= hit ? PURE_RED_565 : s1_data.pixel;
            rgb_reg  <= hit ? PURE_RED_888 : {r8, g8, b8};
            idx_reg  <= IDX_W'(dy) * IDX_CW + IDX_W'(dx);
            hit_reg  <= hit;
            last_reg <= (32'(dx) == CROP_WIDTH - 1) && (32'(dy) == CROP_HEIGHT - 1);
        end
    end

    assign result_valid  = valid_reg;
    assign display_pixel = pix_reg;
    assign feature_rgb   = rgb_reg;
    assign crop_index    = idx_reg;
    assign emphasized    = hit_reg;
    assign last_of_crop  = last_reg;

endmodule
`default_nettype wire

[rtl/rgbcrop_chk.sv]
// Port-level checker for the crop block, bound to the top level.
`default_nettype none
module rgbcrop_chk (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            result_valid,
    input wire logic                            result_ready,
    input wire logic [15:0]                     display_pixel,
    input wire logic [23:0]                     feature_rgb,
    input wire logic [rgbcrop_pkg::IDX_W-1:0]   crop_index,
    input wire logic                            emphasized,
    input wire logic                            last_of_crop
);
    import rgbcrop_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CROP_WIDTH * CROP_HEIGHT - 1);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(display_pixel)
            && $stable(crop_index))
        else $error("stalled transfer changed");

    a_emph: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && emphasized |->
            display_pixel == PURE_RED_565 && feature_rgb == PURE_RED_888)
        else $error("emphasized pixel is not pure red");

    a_expand: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !emphasized |->
            feature_rgb[23:19] == display_pixel[15:11]
            && feature_rgb[15:10] == display_pixel[10:5]
            && feature_rgb[7:3] == display_pixel[4:0])
        else $error("feature word does not match pixel");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_of_crop |-> crop_index == LAST_IDX)
        else $error("last flag on wrong index");

endmodule

bind rgb565_crop_red_emphasis_top rgbcrop_chk u_rgbcrop_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .display_pixel (display_pixel),
    .feature_rgb   (feature_rgb),
    .crop_index    (crop_index),
    .emphasized    (emphasized),
    .last_of_crop  (last_of_crop)
);
`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the RGB565 center crop with red emphasis.
`default_nettype none
module tb_top;
    import rgbcrop_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 100000;
    localparam int unsigned PRINT_CAP   = 40;

    typedef struct packed {
        logic [15:0] pix;
        logic        fs;
    } cam_pixel_t;

    typedef struct packed {
        logic [15:0]      pix;
        logic [23:0]      rgb;
        logic [IDX_W-1:0] idx;
        logic             emph;
        logic             last;
    } crop_result_t;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [ADDR_W-1:0] paddr         = '0;
    logic [DATA_W-1:0] pwdata        = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              pixel_valid   = 1'b0;
    logic              pixel_ready;
    logic [15:0]       pixel_in      = '0;
    logic              frame_start   = 1'b0;
    logic              result_valid;
    logic              result_ready  = 1'b0;
    logic [15:0]       display_pixel;
    logic [23:0]       feature_rgb;
    logic [IDX_W-1:0]  crop_index;
    logic              emphasized;
    logic              last_of_crop;

    rgb565_crop_red_emphasis_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .pixel_valid   (pixel_valid),
        .pixel_ready   (pixel_ready),
        .pixel_in      (pixel_in),
        .frame_start   (frame_start),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .display_pixel (display_pixel),
        .feature_rgb   (feature_rgb),
        .crop_index    (crop_index),
        .emphasized    (emphasized),
        .last_of_crop  (last_of_crop)
    );

    always #4 clk = ~clk;

    cam_pixel_t       frame_pixels[$];
    crop_result_t     crop_expected[$];
    cfg_t             cfg;
    logic [COL_W-1:0] pos_col = '0;
    logic [ROW_W-1:0] pos_row = '0;
    int               plan_col = 0;
    int               plan_row = 0;
    bit               quiet = 1'b0;
    int               in_gap = 0;
    int               out_gap = 0;
    int unsigned      cycle_count = 0;
    int unsigned      error_count = 0;
    int unsigned      pixels_sent = 0;
    int unsigned      results_checked = 0;
    int unsigned      emphasized_seen = 0;
    int unsigned      last_seen = 0;
    int unsigned      settings_applied = 0;
    crop_result_t     want;
    cam_pixel_t       next_pixel;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] wanted);
        if (error_count < PRINT_CAP)
            $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
                     results_checked, what, got, wanted);
        error_count++;
    endtask

    task automatic crop_and_emphasize(input logic [15:0] pix, input logic fs);
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        int               dx;
        int               dy;
        logic [7:0]       r8;
        logic [7:0]       g8;
        logic [7:0]       b8;
        crop_result_t     res;
        if (fs)
        begin
            pos_col = '0;
            pos_row = '0;
        end
        col = pos_col;
        row = pos_row;
        if (int'(pos_col) == int'(FRAME_WIDTH) - 1)
        begin
            pos_col = '0;
            if (int'(pos_row) == int'(FRAME_HEIGHT) - 1)
                pos_row = '0;
            else
                pos_row = pos_row + 1'b1;
        end
        else
            pos_col = pos_col + 1'b1;
        dx = int'(col) - int'(cfg.crop_x_start);
        dy = int'(row) - int'(cfg.crop_y_start);
        if (dx < 0 || dy < 0 || dx >= int'(CROP_WIDTH) || dy >= int'(CROP_HEIGHT))
            return;
        r8 = {pix[15:11], pix[15:13]};
        g8 = {pix[10:5], pix[10:9]};
        b8 = {pix[4:0], pix[4:2]};
        res.pix  = pix;
        res.emph = 1'b0;
        if (cfg.enable_red_emphasis && r8 > cfg.red_floor
            && {1'b0, r8} > {1'b0, g8} + {1'b0, cfg.red_margin}
            && {1'b0, r8} > {1'b0, b8} + {1'b0, cfg.red_margin})
        begin
            r8 = 8'hFF;
            g8 = 8'h00;
            b8 = 8'h00;
            res.pix  = PURE_RED_565;
            res.emph = 1'b1;
        end
        res.rgb  = {r8, g8, b8};
        res.idx  = IDX_W'(dy * int'(CROP_WIDTH) + dx);
        res.last = (dx == int'(CROP_WIDTH) - 1) && (dy == int'(CROP_HEIGHT) - 1);
        crop_expected.push_back(res);
    endtask

    // Drive pixel transfers; hold valid and payload until accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_valid <= 1'b0;
            pixel_in    <= '0;
            frame_start <= 1'b0;
        end
        else
        begin
            if (pixel_valid && pixel_ready)
            begin
                crop_and_emphasize(pixel_in, frame_start);
                pixels_sent++;
            end
            if (!pixel_valid || pixel_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    pixel_valid <= 1'b0;
                end
                else if (!quiet && $urandom_range(15) == 0)
                begin
                    in_gap = $urandom_range(11, 1) - 1;
                    pixel_valid <= 1'b0;
                end
                else if (frame_pixels.size() > 0)
                begin
                    next_pixel = frame_pixels.pop_front();
                    pixel_valid <= 1'b1;
                    pixel_in    <= next_pixel.pix;
                    frame_start <= next_pixel.fs;
                end
                else
                    pixel_valid <= 1'b0;
            end
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (result_valid && result_ready)
            begin
                if (crop_expected.size() == 0)
                    report_mismatch("unexpected result, crop_index", 32'(crop_index), '0);
                else
                begin
                    want = crop_expected.pop_front();
                    if (display_pixel !== want.pix)
                        report_mismatch("display_pixel", 32'(display_pixel), 32'(want.pix));
                    if (feature_rgb !== want.rgb)
                        report_mismatch("feature_rgb", 32'(feature_rgb), 32'(want.rgb));
                    if (crop_index !== want.idx)
                        report_mismatch("crop_index", 32'(crop_index), 32'(want.idx));
                    if (emphasized !== want.emph)
                        report_mismatch("emphasized", 32'(emphasized), 32'(want.emph));
                    if (last_of_crop !== want.last)
                        report_mismatch("last_of_crop", 32'(last_of_crop), 32'(want.last));
                    if (want.emph)
                        emphasized_seen++;
                    if (want.last)
                        last_seen++;
                    results_checked++;
                end
            end
            if (out_gap > 0)
            begin
                out_gap--;
                result_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(15) == 0)
            begin
                out_gap = $urandom_range(11, 1) - 1;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] reg_value(input reg_idx_t r);
        case (r)
            REG_ENABLE: return DATA_W'(cfg.enable_red_emphasis);
            REG_FLOOR:  return DATA_W'(cfg.red_floor);
            REG_MARGIN: return DATA_W'(cfg.red_margin);
            REG_XSTART: return DATA_W'(cfg.crop_x_start);
            REG_YSTART: return DATA_W'(cfg.crop_y_start);
            default:    return '0;
        endcase
    endfunction

    task automatic write_reg(input reg_idx_t r, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(int'(r) * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_ENABLE: cfg.enable_red_emphasis = value[0];
            REG_FLOOR:  cfg.red_floor           = value[7:0];
            REG_MARGIN: cfg.red_margin          = value[7:0];
            REG_XSTART: cfg.crop_x_start        = value[XS_W-1:0];
            REG_YSTART: cfg.crop_y_start        = value[YS_W-1:0];
            default:    ;
        endcase
    endtask

    task automatic check_reg(input reg_idx_t r);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'(int'(r) * 4);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== reg_value(r))
            report_mismatch("prdata", prdata, reg_value(r));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_all_regs();
        check_reg(REG_ENABLE);
        check_reg(REG_FLOOR);
        check_reg(REG_MARGIN);
        check_reg(REG_XSTART);
        check_reg(REG_YSTART);
    endtask

    task automatic set_config(input int en, input int floor_v, input int margin_v,
                              input int x0, input int y0);
        write_reg(REG_ENABLE, DATA_W'(en));
        write_reg(REG_FLOOR,  DATA_W'(floor_v));
        write_reg(REG_MARGIN, DATA_W'(margin_v));
        write_reg(REG_XSTART, DATA_W'(x0));
        write_reg(REG_YSTART, DATA_W'(y0));
        check_all_regs();
        settings_applied++;
    endtask

    task automatic push_pixel(input logic [15:0] pix, input logic fs);
        frame_pixels.push_back('{pix: pix, fs: fs});
        if (fs)
        begin
            plan_col = 0;
            plan_row = 0;
        end
        plan_col++;
        if (plan_col >= int'(FRAME_WIDTH))
        begin
            plan_col = 0;
            plan_row++;
            if (plan_row >= int'(FRAME_HEIGHT))
                plan_row = 0;
        end
    endtask

    function automatic logic [15:0] rand_pixel();
        logic [4:0] r5;
        logic [5:0] g6;
        logic [4:0] b5;
        if ($urandom_range(3) == 0)
        begin
            r5 = 5'($urandom_range(31, 18));
            g6 = 6'($urandom_range(40));
            b5 = 5'($urandom_range(20));
            return {r5, g6, b5};
        end
        return 16'($urandom);
    endfunction

    task automatic skip_to(input int col, input int row);
        while (plan_col != col || plan_row != row)
            push_pixel(rand_pixel(), 1'b0);
    endtask

    // One frame start, then random pixels with stray frame starts.
    task automatic random_frame(input int count);
        push_pixel(rand_pixel(), 1'b1);
        repeat (count)
            push_pixel(rand_pixel(), $urandom_range(49) == 0);
    endtask

    // Wait until every transfer has drained, then let dropped pixels clear.
    task automatic drain();
        do @(negedge clk);
        while (frame_pixels.size() > 0 || pixel_valid || crop_expected.size() > 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        cfg.enable_red_emphasis = 1'b1;
        cfg.red_floor           = 8'd150;
        cfg.red_margin          = 8'd60;
        cfg.crop_x_start        = XS_W'(32);
        cfg.crop_y_start        = YS_W'(12);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_all_regs();

        set_config(1, 150, 60, 32, 0);
        push_pixel(rand_pixel(), 1'b1);
        skip_to(32, 0);
        push_pixel(16'h0000, 1'b0);
        push_pixel(16'hFFFF, 1'b0);
        push_pixel(16'hF800, 1'b0);
        push_pixel(16'hF81F, 1'b0);
        push_pixel(16'h07E0, 1'b0);
        push_pixel(16'h001F, 1'b0);
        push_pixel(16'h9800, 1'b0);
        push_pixel(16'h9000, 1'b0);
        push_pixel(16'hFDE0, 1'b0);
        push_pixel(16'hFE00, 1'b0);
        push_pixel(16'hF817, 1'b0);
        push_pixel(16'hF818, 1'b0);
        push_pixel(16'hF800, 1'b1);
        skip_to(32, 0);
        push_pixel(16'hFFFF, 1'b0);
        skip_to(127, 0);
        push_pixel(16'h9800, 1'b0);
        push_pixel(16'h9800, 1'b0);
        drain();

        set_config(0, 0, 0, 0, 0);
        push_pixel(16'hF800, 1'b1);
        push_pixel(16'hFFFF, 1'b0);
        push_pixel(16'h0000, 1'b0);
        random_frame(20);
        drain();

        set_config(1, 156, 0, 0, 0);
        push_pixel(16'h9800, 1'b1);
        push_pixel(16'hA000, 1'b0);
        push_pixel(16'h0800, 1'b0);
        drain();

        set_config(1, 155, 0, 0, 0);
        push_pixel(16'h9800, 1'b1);
        push_pixel(16'h9000, 1'b0);
        drain();

        // Run past the end of the first row without a frame start so the column wraps.
        set_config(1, 0, 0, 0, 1);
        push_pixel(rand_pixel(), 1'b1);
        repeat (int'(FRAME_WIDTH) + 5)
            push_pixel(rand_pixel(), 1'b0);
        drain();

        set_config(1, 255, 255, $urandom_range(64), 0);
        random_frame(30);
        drain();

        repeat (2)
        begin
            set_config($urandom_range(3) != 0, $urandom_range(255), $urandom_range(120),
                       $urandom_range(64), 0);
            random_frame(50);
            drain();
        end

        quiet = 1'b1;
        set_config(1, $urandom_range(200), $urandom_range(80),
                   $urandom_range(40), 0);
        random_frame(60);
        drain();
        repeat (8) @(posedge clk);

        $display("summary: %0d pixel transfers, %0d window results checked", pixels_sent,
                 results_checked);
        $display("summary: %0d emphasized, %0d last-of-crop, %0d register settings",
                 emphasized_seen, last_seen, settings_applied);
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
`default_nettype wire
